>>> src/assert_macros.svh
// assert_macros.svh: assertion macros used by the top RTL file of the combiner.
// Depends on nothing; build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, suspended while reset is high.
`define IRC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("irc assertion failed");

// Check a property on every rising edge, reset included.
`define IRC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("irc assertion failed");

`else

`define IRC_ASSERT(label, clk, rst, prop)
`define IRC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> src/irc_pkg.sv
// irc_pkg: widths, operation codes, register indexes and the config struct
// for the int32 reduction combiner. Depends on nothing.
`timescale 1ns / 1ps

package irc_pkg;

   localparam int DATA_W          = 32;
   localparam int OP_W            = 4;
   localparam int COUNT_W         = 5;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 8;
   localparam int DEF_MAX_SOURCES = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_BAND   = 4'd0;
   localparam logic [OP_W-1:0] OP_BOR    = 4'd1;
   localparam logic [OP_W-1:0] OP_BXOR   = 4'd2;
   localparam logic [OP_W-1:0] OP_LAND   = 4'd3;
   localparam logic [OP_W-1:0] OP_LOR    = 4'd4;
   localparam logic [OP_W-1:0] OP_LXOR   = 4'd5;
   localparam logic [OP_W-1:0] OP_MAX    = 4'd6;
   localparam logic [OP_W-1:0] OP_MIN    = 4'd7;
   localparam logic [OP_W-1:0] OP_PROD   = 4'd8;
   localparam logic [OP_W-1:0] OP_SUM    = 4'd9;
   localparam logic [OP_W-1:0] OP_MAXLOC = 4'd10;
   localparam logic [OP_W-1:0] OP_MINLOC = 4'd11;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_REDUCE_OP    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_COUNT = 2'd1;

   // Reset values
   localparam logic [OP_W-1:0]    RESET_REDUCE_OP    = OP_SUM;
   localparam logic [COUNT_W-1:0] RESET_SOURCE_COUNT = 5'd2;

   typedef struct packed {
      logic [OP_W-1:0]    reduce_op;
      logic [COUNT_W-1:0] source_count;
   } cfg_type;

   function automatic logic is_loc_op(input logic [OP_W-1:0] op);
      is_loc_op = (op == OP_MAXLOC) || (op == OP_MINLOC);
   endfunction

endpackage

>>> src/irc_csr.sv
// irc_csr: configuration registers of the combiner (operation, sources per element).
// Depends on irc_pkg.
`timescale 1ns / 1ps

module irc_csr
   import irc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take writes; the index picks the register, others drop
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_REDUCE_OP:    cfg_in.reduce_op    = csr_data[OP_W-1:0];
            REG_SOURCE_COUNT: cfg_in.source_count = csr_data[COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reduce_op    <= RESET_REDUCE_OP;
         cfg_ff.source_count <= RESET_SOURCE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/irc_fold.sv
// irc_fold: one accumulator update; folds a source into the running value and location.
// Depends on irc_pkg.
`timescale 1ns / 1ps

module irc_fold
   import irc_pkg::*;
(
   input  logic [OP_W-1:0]          reduce_op,
   input  logic                     first,
   input  logic signed [DATA_W-1:0] acc_value,
   input  logic signed [DATA_W-1:0] acc_location,
   input  logic signed [DATA_W-1:0] src_value,
   input  logic signed [DATA_W-1:0] src_location,
   output logic signed [DATA_W-1:0] next_value,
   output logic signed [DATA_W-1:0] next_location
);

   logic acc_nz;
   logic src_nz;
   logic acc_gt;
   logic acc_eq;
   logic loc_gt;
   logic take_src;
   logic [DATA_W-1:0] product;

   assign acc_nz  = (acc_value != '0);
   assign src_nz  = (src_value != '0);
   assign acc_gt  = (acc_value > src_value);
   assign acc_eq  = (acc_value == src_value);
   assign loc_gt  = (acc_location > src_location);
   assign product = DATA_W'(acc_value * src_value);

   // Winner select for maxloc and minloc; ties go to the smaller location
   always_comb begin
      if (reduce_op == OP_MAXLOC) begin
         take_src = (!acc_gt && !acc_eq) || (acc_eq && loc_gt);
      end else begin
         take_src = acc_gt || (acc_eq && loc_gt);
      end
   end

   always_comb begin
      next_location = acc_location;
      if (first) begin
         next_value    = src_value;
         next_location = src_location;
      end else begin
         case (reduce_op)
            OP_BAND: next_value = acc_value & src_value;
            OP_BOR:  next_value = acc_value | src_value;
            OP_BXOR: next_value = acc_value ^ src_value;
            OP_LAND: next_value = DATA_W'(acc_nz && src_nz);
            OP_LOR:  next_value = DATA_W'(acc_nz || src_nz);
            OP_LXOR: next_value = DATA_W'(acc_nz != src_nz);
            OP_MAX:  next_value = acc_gt ? acc_value : src_value;
            OP_MIN:  next_value = acc_gt ? src_value : acc_value;
            OP_PROD: next_value = product;
            OP_MAXLOC, OP_MINLOC: begin
               next_value    = take_src ? src_value : acc_value;
               next_location = take_src ? src_location : acc_location;
            end
            default: next_value = acc_value + src_value;
         endcase
      end
   end

endmodule

>>> src/int32_reduction_combiner.sv
// int32_reduction_combiner: input register, accumulator fold and result register.
// Depends on irc_pkg, irc_csr, irc_fold and assert_macros.svh.
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   req     | req_valid/req_stall, value, location, last  | in
//   rsp     | rsp_valid/rsp_stall, value, location, end   | out
//   csr     | csr_valid/csr_ready, csr_index, csr_data    | in
//
// One item is taken every cycle unless an element ends while a result is stalled;
// the accumulator loop (one 32x32 product or compare per cycle) sets that rate.
// A result shows on rsp once its last item has passed the input register and the
// fold into the output register. Synchronous reset clears the pipeline valids,
// the source count and the end-of-vector flag and sets the config registers to
// reset values. A stalled result holds in the output register; other items flow.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module int32_reduction_combiner
   import irc_pkg::*;
#(
   parameter int MAX_SOURCES = DEF_MAX_SOURCES
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic signed [DATA_W-1:0] req_location,
   input  logic                     req_last_element,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic signed [DATA_W-1:0] rsp_result_location,
   output logic                     rsp_end_of_vector,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int SIZE_W = $clog2(MAX_SOURCES + 1);
   localparam int CMP_W  = (SIZE_W > COUNT_W) ? SIZE_W : COUNT_W;
   localparam int SEEN_W = $clog2(MAX_SOURCES);

   cfg_type cfg;

   // Input register
   logic                     in_valid_ff, in_valid_in;
   logic signed [DATA_W-1:0] in_value_ff, in_location_ff;
   logic                     in_last_ff;

   // Accumulator
   logic signed [DATA_W-1:0] acc_value_ff, acc_location_ff;
   logic [SEEN_W-1:0]        seen_ff, seen_in;
   logic                     vend_ff, vend_in;

   // Output register
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_value_ff, out_location_ff;
   logic                     out_end_ff;

   logic signed [DATA_W-1:0] fold_value, fold_location;
   logic [CMP_W-1:0]         count_ext, group_size, seen_next;
   logic                     group_done, out_free, fold_fire, req_take;

   irc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   irc_fold u_fold (
      .reduce_op     (cfg.reduce_op),
      .first         (seen_ff == '0),
      .acc_value     (acc_value_ff),
      .acc_location  (acc_location_ff),
      .src_value     (in_value_ff),
      .src_location  (in_location_ff),
      .next_value    (fold_value),
      .next_location (fold_location)
   );

   // Group size: zero means one, saturate at MAX_SOURCES
   always_comb begin
      count_ext = CMP_W'(cfg.source_count);
      if (count_ext == '0) begin
         group_size = CMP_W'(1);
      end else if (count_ext > CMP_W'(MAX_SOURCES)) begin
         group_size = CMP_W'(MAX_SOURCES);
      end else begin
         group_size = count_ext;
      end
   end

   assign seen_next  = CMP_W'(seen_ff) + CMP_W'(1);
   assign group_done = (seen_next >= group_size);

   // Handshake: fold unless a finished element finds the output blocked
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fold_fire = in_valid_ff && (!group_done || out_free);
   assign req_stall = in_valid_ff && !fold_fire;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !fold_fire);

   // Advance the source count and the end-of-vector flag
   always_comb begin
      seen_in = seen_ff;
      vend_in = vend_ff;
      if (fold_fire) begin
         if (group_done) begin
            seen_in = '0;
            vend_in = 1'b0;
         end else begin
            seen_in = seen_ff + SEEN_W'(1);
            vend_in = vend_ff | in_last_ff;
         end
      end
   end

   always_comb begin
      if (fold_fire && group_done) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seen_ff      <= '0;
         vend_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
         vend_ff      <= vend_in;
      end
   end

   // Payload registers: load input on accept, fold on fire, hold result
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_value_ff    <= req_value;
         in_location_ff <= req_location;
         in_last_ff     <= req_last_element;
      end
      if (fold_fire) begin
         acc_value_ff    <= fold_value;
         acc_location_ff <= fold_location;
      end
      if (fold_fire && group_done) begin
         out_value_ff    <= fold_value;
         out_location_ff <= is_loc_op(cfg.reduce_op) ? fold_location : '0;
         out_end_ff      <= vend_ff | in_last_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_value    = out_value_ff;
   assign rsp_result_location = out_location_ff;
   assign rsp_end_of_vector   = out_end_ff;

   `IRC_ASSERT(a_no_overwrite, clock, reset, (fold_fire && group_done) |-> out_free)
   `IRC_ASSERT(a_count_clears, clock, reset, (fold_fire && group_done) |=> (seen_ff == '0))
   `IRC_ASSERT(a_stall_needs_item, clock, reset, req_stall |-> in_valid_ff)
   `IRC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> (!out_valid_ff && !in_valid_ff))

endmodule

>>> tb/sv/irc_element_checker.sv
// irc_element_checker: watches the source, result and register channels of the
// int32 reduction combiner, predicts each combined element and compares results.
// Depends on irc_pkg.
`timescale 1ns / 1ps

module irc_element_checker
   import irc_pkg::*;
#(
   parameter int MAX_SOURCES = DEF_MAX_SOURCES
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic signed [DATA_W-1:0] req_location,
   input  logic                     req_last_element,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_result_value,
   input  logic signed [DATA_W-1:0] rsp_result_location,
   input  logic                     rsp_end_of_vector,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output int                       mismatches,
   output int                       elements_pending,
   output int                       sources_taken,
   output int                       elements_checked
);

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] location;
      logic              end_of_vector;
   } element_type;

   // Combined elements predicted but not yet seen on the result channel
   element_type expected_elements[$];

   // Register copy and running accumulator of the element being folded
   logic [OP_W-1:0]          cur_op;
   logic [COUNT_W-1:0]       cur_count;
   logic signed [DATA_W-1:0] acc_value;
   logic signed [DATA_W-1:0] acc_location;
   logic                     end_seen;
   int                       folded;

   // Zero means one source per element; anything above the limit saturates
   function automatic int group_len(input logic [COUNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_SOURCES) return MAX_SOURCES;
      return int'(count);
   endfunction

   // Fold one source into the running element; queue the element when complete
   task automatic fold_source(input logic signed [DATA_W-1:0] v,
                              input logic signed [DATA_W-1:0] loc,
                              input logic                     last);
      logic        better;
      logic        tie;
      element_type done;
      if (folded == 0) begin
         acc_value    = v;
         acc_location = loc;
      end else begin
         case (cur_op)
            OP_BAND: acc_value = acc_value & v;
            OP_BOR:  acc_value = acc_value | v;
            OP_BXOR: acc_value = acc_value ^ v;
            OP_LAND: acc_value = ((acc_value != 0) && (v != 0)) ? 1 : 0;
            OP_LOR:  acc_value = ((acc_value != 0) || (v != 0)) ? 1 : 0;
            OP_LXOR: acc_value = ((acc_value != 0) != (v != 0)) ? 1 : 0;
            OP_MAX:  if (!(acc_value > v)) acc_value = v;
            OP_MIN:  if (acc_value > v) acc_value = v;
            OP_PROD: acc_value = acc_value * v;
            OP_MAXLOC, OP_MINLOC: begin
               better = (cur_op == OP_MAXLOC) ? (acc_value < v) : (acc_value > v);
               // equal values go to the smaller location
               tie = (acc_value == v) && (acc_location > loc);
               if (better || tie) begin
                  acc_value    = v;
                  acc_location = loc;
               end
            end
            default: acc_value = acc_value + v;
         endcase
      end
      end_seen = end_seen | last;
      folded++;
      if (folded >= group_len(cur_count)) begin
         done.value         = acc_value;
         done.location      = (cur_op == OP_MAXLOC || cur_op == OP_MINLOC) ?
                              acc_location : '0;
         done.end_of_vector = end_seen;
         expected_elements.push_back(done);
         acc_value    = '0;
         acc_location = '0;
         end_seen     = 1'b0;
         folded       = 0;
      end
   endtask

   always @(posedge clock) begin
      element_type want;
      if (reset) begin
         cur_op       = RESET_REDUCE_OP;
         cur_count    = RESET_SOURCE_COUNT;
         acc_value    = '0;
         acc_location = '0;
         end_seen     = 1'b0;
         folded       = 0;
         expected_elements.delete();
         mismatches       = 0;
         sources_taken    = 0;
         elements_checked = 0;
      end else begin
         // Compare the result taken at this edge with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_elements.size() == 0) begin
               $error("result with no element pending: value %0d location %0d",
                      rsp_result_value, rsp_result_location);
               mismatches++;
            end else begin
               want = expected_elements.pop_front();
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %0d, actual %0d",
                         $signed(want.value), rsp_result_value);
                  mismatches++;
               end
               if (rsp_result_location !== want.location) begin
                  $error("result_location: expected %0d, actual %0d",
                         $signed(want.location), rsp_result_location);
                  mismatches++;
               end
               if (rsp_end_of_vector !== want.end_of_vector) begin
                  $error("end_of_vector: expected %0b, actual %0b",
                         want.end_of_vector, rsp_end_of_vector);
                  mismatches++;
               end
               elements_checked++;
            end
         end
         // Track register writes; indexes past the list are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_REDUCE_OP:    cur_op    = csr_data[OP_W-1:0];
               REG_SOURCE_COUNT: cur_count = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            fold_source(req_value, req_location, req_last_element);
            sources_taken++;
         end
      end
      elements_pending = expected_elements.size();
   end

endmodule

>>> tb/sv/tb.sv
// tb: drives sources and register writes into int32_reduction_combiner under
// several idle patterns and gives the verdict. Depends on irc_pkg and irc_element_checker.
`timescale 1ns / 1ps

module tb
   import irc_pkg::*;
;

   localparam int RANDOM_SOURCES = 600;
   localparam int PHASE_SOURCES  = 30;
   localparam int DRAIN_CYCLES   = 8;
   localparam int IDLE_LIMIT     = 2000;

   // Codes outside the documented lists
   localparam logic [OP_W-1:0]        OP_SPARE_FIRST = 4'd12;
   localparam logic [OP_W-1:0]        OP_SPARE_LAST  = 4'd15;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI   = 2'd3;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_value        = '0;
   logic signed [DATA_W-1:0] req_location     = '0;
   logic                     req_last_element = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic signed [DATA_W-1:0] rsp_result_location;
   logic                     rsp_end_of_vector;
   logic                     csr_valid        = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index        = '0;
   logic [CSR_DATA_W-1:0]    csr_data         = '0;

   int mismatches;
   int elements_pending;
   int sources_taken;
   int elements_checked;

   int send_idle_pct    = 0;
   int stall_pct        = 0;
   int sources_sent     = 0;
   int settings_written = 0;
   int quiet_cycles     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   int32_reduction_combiner dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_value           (req_value),
      .req_location        (req_location),
      .req_last_element    (req_last_element),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_value    (rsp_result_value),
      .rsp_result_location (rsp_result_location),
      .rsp_end_of_vector   (rsp_end_of_vector),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   irc_element_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_value           (req_value),
      .req_location        (req_location),
      .req_last_element    (req_last_element),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_value    (rsp_result_value),
      .rsp_result_location (rsp_result_location),
      .rsp_end_of_vector   (rsp_end_of_vector),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .mismatches          (mismatches),
      .elements_pending    (elements_pending),
      .sources_taken       (sources_taken),
      .elements_checked    (elements_checked)
   );

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // End the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: %0d cycles with no item moving", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int group_len(input logic [COUNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > DEF_MAX_SOURCES) return DEF_MAX_SOURCES;
      return int'(count);
   endfunction

   // Extremes, small values that tie and zero out often, and full random words
   function automatic logic [DATA_W-1:0] pick_value();
      int near;
      near = $urandom_range(8);
      case ($urandom_range(9))
         0:       return 32'h7FFFFFFF;
         1:       return 32'h80000000;
         2:       return '0;
         3, 4, 5: return near - 4;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_location();
      int near;
      near = $urandom_range(8);
      if ($urandom_range(3) == 0) return near - 4;
      return $urandom();
   endfunction

   // Present one source item at a falling edge and hold it until taken
   task automatic send_source(input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] loc,
                              input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_value        <= v;
      req_location     <= loc;
      req_last_element <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sources_sent++;
   endtask

   task automatic send_group(input int len);
      logic vector_tail;
      vector_tail = ($urandom_range(3) == 0);
      repeat (len) send_source(pick_value(), pick_location(),
                               vector_tail || ($urandom_range(19) == 0));
   endtask

   // Drop valid, wait for every predicted element, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (elements_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] word);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= word;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Write both registers, filler in the unused upper bits, and sometimes a spare index
   task automatic configure(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] word;
      settle();
      word = CSR_DATA_W'($urandom());
      word[OP_W-1:0] = op;
      write_reg(REG_REDUCE_OP, word);
      word = CSR_DATA_W'($urandom());
      word[COUNT_W-1:0] = count;
      write_reg(REG_SOURCE_COUNT, word);
      if ($urandom_range(2) == 0)
         write_reg(($urandom_range(1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                   CSR_DATA_W'($urandom()));
      settings_written++;
   endtask

   initial begin
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] count;
      logic [DATA_W-1:0]  a;
      logic [DATA_W-1:0]  b;
      int                 len;
      int                 phase;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: sum of pairs, wrapping past the top
      send_source(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
      send_source(32'h00000001, 32'h80000000, 1'b1);

      // One pair per operation at the value extremes; loc ops get a tie
      for (int code = OP_BAND; code <= OP_MINLOC; code++) begin
         if (code != OP_SUM) begin
            op = OP_W'(code);
            configure(op, 5'd2);
            if (op == OP_MAXLOC || op == OP_MINLOC) begin
               a = (op == OP_MAXLOC) ? 32'h7FFFFFFF : 32'h80000000;
               b = a;
            end else begin
               a = op[0] ? 32'h80000000 : 32'h7FFFFFFF;
               b = op[1] ? 32'hFFFFFFFF : 32'h00000000;
            end
            send_source(a, 32'h7FFFFFFF, 1'b0);
            send_source(b, 32'h80000000, op[0]);
         end
      end

      // Spare op code with a zero count, plus writes to indexes past the list
      configure(OP_SPARE_FIRST, 5'd0);
      write_reg(REG_SPARE_LO, 8'hFF);
      write_reg(REG_SPARE_HI, 8'h00);
      send_source(32'h80000001, 32'h12345678, 1'b1);

      // Change the operation and count halfway through an element
      configure(OP_SUM, 5'd3);
      send_source(32'h00010000, 32'h00000005, 1'b0);
      settle();
      write_reg(REG_REDUCE_OP, {4'hA, OP_PROD});
      write_reg(REG_SOURCE_COUNT, 8'hE2);
      settings_written++;
      send_source(32'h00010001, 32'hFFFFFFFB, 1'b0);

      // Random phases, cycling through the idle patterns
      sources_sent = 0;
      phase = 0;
      while (sources_sent < RANDOM_SOURCES) begin
         case (phase % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 54; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         case (phase)
            0:       begin op = OP_SPARE_LAST; count = 5'd31; end
            1:       begin op = OP_BAND;       count = 5'd16; end
            2:       begin op = OP_MINLOC;     count = 5'd1;  end
            default: begin
               op = ($urandom_range(4) == 0) ? OP_W'($urandom_range(OP_SPARE_LAST)) :
                                               OP_W'($urandom_range(OP_MINLOC));
               case ($urandom_range(9))
                  0:       count = 5'd16;
                  1:       count = 5'd0;
                  2:       count = COUNT_W'($urandom_range(31, 17));
                  default: count = COUNT_W'($urandom_range(6, 1));
               endcase
            end
         endcase
         configure(op, count);
         len = group_len(count);
         repeat ((PHASE_SOURCES + len - 1) / len) send_group(len);
         // Sometimes leave an element open across the next register write
         if (len > 1 && $urandom_range(3) == 0)
            repeat ($urandom_range(len - 1, 1))
               send_source(pick_value(), pick_location(), 1'($urandom_range(1)));
         phase++;
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      settle();

      $display("Summary: %0d sources folded into %0d checked elements over %0d settings,",
               sources_taken, elements_checked, settings_written);
      $display("  all operations and spare codes, group sizes 0 to 31, four idle patterns.");
      if (mismatches == 0 && elements_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/irc_pkg.sv
src/irc_csr.sv
src/irc_fold.sv
src/int32_reduction_combiner.sv
tb/sv/irc_element_checker.sv
tb/sv/tb.sv
